@@ design/sssp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg
// shared types, sizes and codes of the single source shortest path block
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int WEIGHT_BITS = 16;

    // node index (zero based) and node count widths
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    // a path has fewer edges than there are nodes, so IDX_W bits above a weight suffice
    localparam int DIST_W = WEIGHT_BITS + IDX_W;

    // fixed field widths of the stream items
    localparam int NODE_W     = 7;
    localparam int IN_W_W     = 16;
    localparam int OUT_DIST_W = 23;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam logic [OUT_DIST_W-1:0] DIST_MAX     = 23'h3FFFFF;
    localparam logic [OUT_DIST_W-1:0] DIST_UNREACH = 23'h7FFFFF;

    // weight matrix: upper triangle addressed by {lower index, higher index}
    localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
    localparam int MAT_AW    = 2 * IDX_W;
    localparam int ENTRY_W   = WEIGHT_BITS + 1;

    // configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 7;
    localparam logic [CFG_AW-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_SOURCE_NODE = 1'd1;
    localparam logic [CFG_DW-1:0] NODE_COUNT_RST  = 7'd64;
    localparam logic [CFG_DW-1:0] SOURCE_NODE_RST = 7'd1;

    // item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic                   valid;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_WR,
        ST_RUN_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_RELAX,
        ST_RELAX_END,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y);
        return (x < y) ? {x, y} : {y, x};
    endfunction

endpackage

@@ design/sssp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sssp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/single_source_shortest_path.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path
// dijkstra over an undirected weighted graph held in an on-chip weight matrix
// ----------------------------------------------------------------------------
// Edge items (tuser = 0) are written into a weight matrix that keeps the
// smallest weight per node pair; an edge naming node 0 or a node above the
// node count is dropped. A valid edge is read when taken, then compared and
// written back in the edge write state. An end item (tuser = 1) with a valid
// count and source runs dijkstra from source_node over nodes 1..node_count and
// then emits one result per node other than the source in ascending order,
// with distance -1 for an unreachable node and tlast on the final result.
// Every settled node costs one scan of the distance memory and one pass over
// its matrix row, one entry per cycle on each memory's read port, plus the
// scan end, pick and relax end states; a closing scan finds no node left.
// Each result is read, then loaded once the output is free. After every end
// item, and after reset, the matrix is wiped one entry a cycle, all 4096
// (MAX_NODES * MAX_NODES) entries, with s_tready low; config writes are still
// taken then. Config writes are meant for idle time only.
// ----------------------------------------------------------------------------
module single_source_shortest_path (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [sssp_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [sssp_pkg::CFG_DW-1:0]       cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sssp_pkg::S_TDATA_W-1:0]    s_tdata,  // end_a, end_b, weight
    input  logic                              s_tuser,  // kind
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sssp_pkg::M_TDATA_W-1:0]    m_tdata,  // node, distance
    output logic                              m_tlast   // last
);

    localparam int IDX_W  = sssp_pkg::IDX_W;
    localparam int CNT_W  = sssp_pkg::CNT_W;
    localparam int DIST_W = sssp_pkg::DIST_W;
    localparam int NODE_W = sssp_pkg::NODE_W;
    localparam int WB     = sssp_pkg::WEIGHT_BITS;

    sssp_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [sssp_pkg::CFG_DW-1:0] node_count_reg;
    logic [sssp_pkg::CFG_DW-1:0] source_node_reg;

    // edge update
    logic [sssp_pkg::MAT_AW-1:0] edge_addr_reg;
    logic [WB-1:0]               edge_w_reg;

    // wipe pass address
    logic [sssp_pkg::MAT_AW-1:0] clr_addr_reg;

    // node walk counter shared by scan, relax and output
    logic [IDX_W-1:0]            idx_reg;

    // read pipeline: one stage to cover memory latency
    logic                        pipe_valid_reg;
    logic [IDX_W-1:0]            pipe_idx_reg;

    // nearest unsettled node of the current scan
    logic                        found_reg;
    logic [DIST_W-1:0]           min_dist_reg;
    logic [IDX_W-1:0]            min_idx_reg;

    // per node flags, reset at run start with only the source reached
    logic [sssp_pkg::MAX_NODES-1:0] reached_reg;
    logic [sssp_pkg::MAX_NODES-1:0] settled_reg;

    // output register
    logic                           m_tvalid_reg;
    logic [sssp_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tlast_reg;

    // memory ports
    logic                        mat_we, mat_re;
    logic [sssp_pkg::MAT_AW-1:0] mat_waddr, mat_raddr;
    sssp_pkg::entry_t            mat_wdata, mat_q;
    logic [sssp_pkg::ENTRY_W-1:0] mat_q_raw;

    logic                        dist_we, dist_re;
    logic [IDX_W-1:0]            dist_waddr, dist_raddr;
    logic [DIST_W-1:0]           dist_wdata, dist_q;

    // --------------------------------------------------------------------
    // decoded inputs and run parameters
    // --------------------------------------------------------------------
    logic [NODE_W-1:0]  in_a, in_b;
    logic [WB-1:0]      in_w;
    logic [IDX_W-1:0]   a_idx, b_idx;
    logic               in_accept;
    logic               edge_ok;
    logic               run_ok;
    logic [CNT_W-1:0]   eff_n;
    logic [IDX_W-1:0]   src_idx;
    logic [IDX_W-1:0]   idx_end;   // index of the highest node
    logic [IDX_W-1:0]   last_idx;  // index of the last reported node
    logic               idx_last;
    logic               out_free;
    logic               scan_phase, relax_phase;
    logic               scan_hit, relax_upd;
    logic [DIST_W:0]    cand;
    logic [sssp_pkg::OUT_DIST_W-1:0] out_dist;

    assign in_a = s_tdata[NODE_W-1:0];
    assign in_b = s_tdata[2*NODE_W-1:NODE_W];
    assign in_w = WB'(s_tdata[2*NODE_W+sssp_pkg::IN_W_W-1:2*NODE_W]);

    assign a_idx = IDX_W'(in_a - 1'b1);
    assign b_idx = IDX_W'(in_b - 1'b1);

    // a count above the node limit acts as the limit
    assign eff_n = (32'(node_count_reg) > sssp_pkg::MAX_NODES) ?
                   CNT_W'(sssp_pkg::MAX_NODES) : CNT_W'(node_count_reg);

    assign in_accept = s_tvalid && s_tready;

    assign edge_ok = (in_a != '0) && (in_b != '0) &&
                     (32'(in_a) <= 32'(eff_n)) && (32'(in_b) <= 32'(eff_n));

    // fewer than two nodes or a bad source gives no results at all
    assign run_ok = (eff_n >= CNT_W'(2)) && (source_node_reg != '0) &&
                    (32'(source_node_reg) <= 32'(eff_n));

    assign src_idx  = IDX_W'(source_node_reg - 1'b1);
    assign idx_end  = IDX_W'(eff_n - 1'b1);
    assign last_idx = (src_idx == idx_end) ? IDX_W'(idx_end - 1'b1) : idx_end;
    assign idx_last = (idx_reg == idx_end);

    assign out_free = !m_tvalid_reg || m_tready;

    assign scan_phase  = (state_reg == sssp_pkg::ST_SCAN) ||
                         (state_reg == sssp_pkg::ST_SCAN_END);
    assign relax_phase = (state_reg == sssp_pkg::ST_RELAX) ||
                         (state_reg == sssp_pkg::ST_RELAX_END);

    assign mat_q = sssp_pkg::entry_t'(mat_q_raw);

    // scan: strict compare keeps the lowest index on ties
    assign scan_hit = pipe_valid_reg && scan_phase &&
                      reached_reg[pipe_idx_reg] && !settled_reg[pipe_idx_reg] &&
                      (!found_reg || (dist_q < min_dist_reg));

    // relax: one neighbor per cycle, dist write lands one entry behind the read
    assign cand = {1'b0, min_dist_reg} + (DIST_W + 1)'(mat_q.weight);
    assign relax_upd = pipe_valid_reg && relax_phase && mat_q.valid &&
                       !settled_reg[pipe_idx_reg] &&
                       (!reached_reg[pipe_idx_reg] || (cand < {1'b0, dist_q}));

    // distance as reported, saturated, -1 when never reached
    always_comb begin
        if (!reached_reg[idx_reg]) begin
            out_dist = sssp_pkg::DIST_UNREACH;
        end else if (64'(dist_q) > 64'(sssp_pkg::DIST_MAX)) begin
            out_dist = sssp_pkg::DIST_MAX;
        end else begin
            out_dist = sssp_pkg::OUT_DIST_W'(dist_q);
        end
    end

    // --------------------------------------------------------------------
    // next state
    // --------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sssp_pkg::ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = sssp_pkg::ST_IDLE;
                end
            end
            sssp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == sssp_pkg::KIND_END) begin
                        state_next = run_ok ? sssp_pkg::ST_RUN_INIT : sssp_pkg::ST_CLEAR;
                    end else if (edge_ok) begin
                        state_next = sssp_pkg::ST_EDGE_WR;
                    end
                end
            end
            sssp_pkg::ST_EDGE_WR:   state_next = sssp_pkg::ST_IDLE;
            sssp_pkg::ST_RUN_INIT:  state_next = sssp_pkg::ST_SCAN;
            sssp_pkg::ST_SCAN: begin
                if (idx_last) begin
                    state_next = sssp_pkg::ST_SCAN_END;
                end
            end
            sssp_pkg::ST_SCAN_END:  state_next = sssp_pkg::ST_PICK;
            sssp_pkg::ST_PICK: begin
                state_next = found_reg ? sssp_pkg::ST_RELAX : sssp_pkg::ST_OUT_RD;
            end
            sssp_pkg::ST_RELAX: begin
                if (idx_last) begin
                    state_next = sssp_pkg::ST_RELAX_END;
                end
            end
            sssp_pkg::ST_RELAX_END: state_next = sssp_pkg::ST_SCAN;
            sssp_pkg::ST_OUT_RD: begin
                // the source is skipped
                if (idx_reg == src_idx) begin
                    if (idx_last) begin
                        state_next = sssp_pkg::ST_CLEAR;
                    end
                end else begin
                    state_next = sssp_pkg::ST_OUT_LD;
                end
            end
            sssp_pkg::ST_OUT_LD: begin
                if (out_free) begin
                    state_next = (idx_reg == last_idx) ? sssp_pkg::ST_CLEAR :
                                                         sssp_pkg::ST_OUT_RD;
                end
            end
            default: state_next = sssp_pkg::ST_CLEAR;
        endcase
    end

    // --------------------------------------------------------------------
    // memory controls and handshake
    // --------------------------------------------------------------------
    always_comb begin
        s_tready   = 1'b0;
        mat_we     = 1'b0;
        mat_waddr  = edge_addr_reg;
        mat_wdata  = '{valid: 1'b1, weight: edge_w_reg};
        mat_re     = 1'b0;
        mat_raddr  = sssp_pkg::mat_addr(a_idx, b_idx);
        dist_we    = relax_upd;
        dist_waddr = pipe_idx_reg;
        dist_wdata = DIST_W'(cand);
        dist_re    = 1'b0;
        dist_raddr = idx_reg;
        unique case (state_reg)
            sssp_pkg::ST_CLEAR: begin
                mat_we    = 1'b1;
                mat_waddr = clr_addr_reg;
                mat_wdata = '0;
            end
            sssp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                mat_re   = in_accept && (s_tuser == sssp_pkg::KIND_EDGE) && edge_ok;
            end
            sssp_pkg::ST_EDGE_WR: begin
                // keep the lighter of stored and new edge
                mat_we = !mat_q.valid || (edge_w_reg < mat_q.weight);
            end
            sssp_pkg::ST_RUN_INIT: begin
                dist_we    = 1'b1;
                dist_waddr = src_idx;
                dist_wdata = '0;
            end
            sssp_pkg::ST_SCAN: begin
                dist_re = 1'b1;
            end
            sssp_pkg::ST_RELAX: begin
                mat_re    = 1'b1;
                mat_raddr = sssp_pkg::mat_addr(min_idx_reg, idx_reg);
                dist_re   = 1'b1;
            end
            sssp_pkg::ST_OUT_RD: begin
                dist_re = (idx_reg != src_idx);
            end
            sssp_pkg::ST_SCAN_END, sssp_pkg::ST_PICK,
            sssp_pkg::ST_RELAX_END, sssp_pkg::ST_OUT_LD: begin
            end
            default: begin
            end
        endcase
    end

    // --------------------------------------------------------------------
    // registers
    // --------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sssp_pkg::ST_CLEAR;
            node_count_reg  <= sssp_pkg::NODE_COUNT_RST;
            source_node_reg <= sssp_pkg::SOURCE_NODE_RST;
            clr_addr_reg    <= '0;
            pipe_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            reached_reg     <= '0;
            settled_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                if (cfg_addr == sssp_pkg::REG_NODE_COUNT) begin
                    node_count_reg <= cfg_wdata;
                end else if (cfg_addr == sssp_pkg::REG_SOURCE_NODE) begin
                    source_node_reg <= cfg_wdata;
                end
            end

            // wraps back to zero at the end of each pass
            if (state_reg == sssp_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            pipe_valid_reg <= (state_reg == sssp_pkg::ST_SCAN) ||
                              (state_reg == sssp_pkg::ST_RELAX);

            if ((state_reg == sssp_pkg::ST_RUN_INIT) ||
                (state_reg == sssp_pkg::ST_RELAX_END)) begin
                found_reg <= 1'b0;
            end else if (scan_hit) begin
                found_reg <= 1'b1;
            end

            if (state_reg == sssp_pkg::ST_RUN_INIT) begin
                // only the source starts out reached
                reached_reg <= {{(sssp_pkg::MAX_NODES - 1){1'b0}}, 1'b1} << src_idx;
                settled_reg <= '0;
            end else begin
                if ((state_reg == sssp_pkg::ST_PICK) && found_reg) begin
                    settled_reg[min_idx_reg] <= 1'b1;
                end
                if (relax_upd) begin
                    reached_reg[pipe_idx_reg] <= 1'b1;
                end
            end

            if ((state_reg == sssp_pkg::ST_OUT_LD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and counters without reset
    always_ff @(posedge aclk) begin
        if (state_reg == sssp_pkg::ST_IDLE) begin
            edge_addr_reg <= sssp_pkg::mat_addr(a_idx, b_idx);
            edge_w_reg    <= in_w;
        end

        pipe_idx_reg <= idx_reg;

        if (scan_hit) begin
            min_dist_reg <= dist_q;
            min_idx_reg  <= pipe_idx_reg;
        end

        unique case (state_reg)
            sssp_pkg::ST_SCAN, sssp_pkg::ST_RELAX: begin
                idx_reg <= idx_last ? '0 : IDX_W'(idx_reg + 1'b1);
            end
            sssp_pkg::ST_OUT_RD: begin
                if (idx_reg == src_idx) begin
                    idx_reg <= IDX_W'(idx_reg + 1'b1);
                end
            end
            sssp_pkg::ST_OUT_LD: begin
                if (out_free) begin
                    idx_reg <= IDX_W'(idx_reg + 1'b1);
                end
            end
            sssp_pkg::ST_CLEAR, sssp_pkg::ST_IDLE, sssp_pkg::ST_EDGE_WR,
            sssp_pkg::ST_RUN_INIT, sssp_pkg::ST_SCAN_END, sssp_pkg::ST_PICK,
            sssp_pkg::ST_RELAX_END: begin
                idx_reg <= '0;
            end
            default: idx_reg <= '0;
        endcase

        if ((state_reg == sssp_pkg::ST_OUT_LD) && out_free) begin
            m_tdata_reg <= sssp_pkg::M_TDATA_W'({out_dist, NODE_W'(idx_reg + 1'b1)});
            m_tlast_reg <= (idx_reg == last_idx);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // --------------------------------------------------------------------
    // memories
    // --------------------------------------------------------------------
    sssp_ram #(
        .DEPTH (sssp_pkg::MAT_DEPTH),
        .WIDTH (sssp_pkg::ENTRY_W)
    ) u_matrix (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_q_raw)
    );

    // distances are only trusted where the reached flag is set
    sssp_ram #(
        .DEPTH (sssp_pkg::MAX_NODES),
        .WIDTH (DIST_W)
    ) u_dist (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_q)
    );

endmodule

@@ design/sssp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_checker
// port level checks of the shortest path block, bound to the top level
// ----------------------------------------------------------------------------
module sssp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sssp_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sssp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reported node is never zero
    a_node_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[sssp_pkg::NODE_W-1:0] != '0))
        else $error("result names node zero");

    // distance is either -1 or non-negative
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[29:7] == sssp_pkg::DIST_UNREACH) || !m_tdata[29]))
        else $error("distance out of range");

    // matrix wipe follows reset
    a_wipe_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted during wipe after reset");

    // an end item starts a run or a wipe
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == sssp_pkg::KIND_END) |=> !s_tready)
        else $error("input accepted right after end item");

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/single_source_shortest_path_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path_tb
// self-checking bench for the dijkstra shortest path block
// ----------------------------------------------------------------------------
// Edge items and end items are streamed into the block. A distance board keeps
// its own copy of the weight matrix and the two registers, solves each graph
// when its end item is accepted and queues the per-node distances it expects.
// Every result item leaving the block is checked against the oldest queued
// distance. A short directed part covers the field extremes and the corner
// cases (node count zero, one and above the matrix size, bad source, bad
// endpoints, self loops, repeated edges). Random phases follow, each with its
// own register setting and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module single_source_shortest_path_tb;

    localparam int MAX_NODES   = sssp_pkg::MAX_NODES;
    localparam int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS;
    localparam int NODE_W      = sssp_pkg::NODE_W;
    localparam int IN_W_W      = sssp_pkg::IN_W_W;
    localparam int OUT_DIST_W  = sssp_pkg::OUT_DIST_W;
    localparam int S_TDATA_W   = sssp_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = sssp_pkg::M_TDATA_W;
    localparam int CFG_AW      = sssp_pkg::CFG_AW;
    localparam int CFG_DW      = sssp_pkg::CFG_DW;

    // wait bounds for a full run and a full matrix wipe
    localparam int RUN_CYCLES   = MAX_NODES * (2 * MAX_NODES + 5);
    localparam int CLEAR_CYCLES = MAX_NODES * MAX_NODES;
    localparam int SETTLE_WAIT  = RUN_CYCLES + CLEAR_CYCLES + 64;
    localparam int TAIL_WAIT    = RUN_CYCLES + 64;
    // cycles with no item moved on either side before the run is given up
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int ITEM_TARGET    = 270;
    localparam int REPORT_LIMIT   = 10;

    // one expected result item
    typedef struct {
        logic [NODE_W-1:0]     node;
        logic [OUT_DIST_W-1:0] distance;
        logic                  last;
    } distance_t;

    // ------------------------------------------------------------------------
    // distance board: own model of the block plus the queue of expected items
    // ------------------------------------------------------------------------
    class distance_board;
        logic [CFG_DW-1:0]      node_count;
        logic [CFG_DW-1:0]      source_node;
        bit                     edge_ok [MAX_NODES][MAX_NODES];
        bit [WEIGHT_BITS-1:0]   edge_w  [MAX_NODES][MAX_NODES];
        distance_t              expected_distances[$];
        int                     mismatches;

        function new();
            node_count  = sssp_pkg::NODE_COUNT_RST;
            source_node = sssp_pkg::SOURCE_NODE_RST;
            mismatches  = 0;
            wipe_matrix();
        endfunction

        function void wipe_matrix();
            foreach (edge_ok[i, j]) begin
                edge_ok[i][j] = 1'b0;
                edge_w[i][j]  = '0;
            end
        endfunction

        function int live_nodes();
            return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        endfunction

        function int pending();
            return expected_distances.size();
        endfunction

        function void note_config(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
            if (idx == sssp_pkg::REG_NODE_COUNT) begin
                node_count = value;
            end else if (idx == sssp_pkg::REG_SOURCE_NODE) begin
                source_node = value;
            end
        endfunction

        // dijkstra with a linear scan for the nearest unsettled node
        function void predict_distances(int n);
            longint        path_len [MAX_NODES];
            bit            reached  [MAX_NODES];
            bit            settled  [MAX_NODES];
            int            u;
            bit            found;
            longint        cand;
            distance_t     res;
            int            first;

            foreach (path_len[i]) begin
                path_len[i] = 0;
                reached[i]  = 1'b0;
                settled[i]  = 1'b0;
            end
            reached[source_node - 1] = 1'b1;
            found = 1'b1;
            while (found) begin
                found = 1'b0;
                u     = 0;
                for (int i = 0; i < n; i++) begin
                    if (reached[i] && !settled[i] &&
                        (!found || path_len[i] < path_len[u])) begin
                        u     = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    settled[u] = 1'b1;
                    for (int v = 0; v < n; v++) begin
                        if (edge_ok[u][v] && !settled[v]) begin
                            cand = path_len[u] + edge_w[u][v];
                            if (!reached[v] || cand < path_len[v]) begin
                                path_len[v] = cand;
                                reached[v]  = 1'b1;
                            end
                        end
                    end
                end
            end

            first = expected_distances.size();
            for (int i = 0; i < n; i++) begin
                if (i + 1 != int'(source_node)) begin
                    res.node = NODE_W'(i + 1);
                    if (!reached[i]) begin
                        res.distance = sssp_pkg::DIST_UNREACH;
                    end else if (path_len[i] > longint'(sssp_pkg::DIST_MAX)) begin
                        res.distance = sssp_pkg::DIST_MAX;
                    end else begin
                        res.distance = OUT_DIST_W'(path_len[i]);
                    end
                    res.last = 1'b0;
                    expected_distances = {expected_distances, res};
                end
            end
            // flag the final node of this run
            if (expected_distances.size() > first) begin
                expected_distances[expected_distances.size() - 1].last = 1'b1;
            end
        endfunction

        function void note_input(logic kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                 logic [IN_W_W-1:0] w);
            int n;
            n = live_nodes();
            if (kind == sssp_pkg::KIND_EDGE) begin
                if (a == 0 || b == 0 || a > n || b > n) begin
                    return;
                end
                if (!edge_ok[a - 1][b - 1] || w < edge_w[a - 1][b - 1]) begin
                    edge_ok[a - 1][b - 1] = 1'b1;
                    edge_ok[b - 1][a - 1] = 1'b1;
                    edge_w[a - 1][b - 1]  = w;
                    edge_w[b - 1][a - 1]  = w;
                end
            end else begin
                if (n != 0 && source_node != 0 && source_node <= n) begin
                    predict_distances(n);
                end
                wipe_matrix();
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic last);
            distance_t want;
            logic [NODE_W-1:0]     got_node;
            logic [OUT_DIST_W-1:0] got_dist;
            got_node = data[NODE_W-1:0];
            got_dist = data[NODE_W +: OUT_DIST_W];
            if (expected_distances.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected result: node %0d distance %0h last %b",
                             $realtime, got_node, got_dist, last);
                end
                return;
            end
            want = expected_distances.pop_front();
            if (got_node !== want.node || got_dist !== want.distance ||
                last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] mismatch: expected node %0d dist %0h last %b",
                             $realtime, want.node, want.distance, want.last);
                    $display("          actual   node %0d dist %0h last %b",
                             got_node, got_dist, last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_AW-1:0]       cfg_addr  = '0;
    logic [CFG_DW-1:0]       cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;   // end_a, end_b, weight
    logic                    s_tuser   = 1'b0; // kind
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;          // node, distance
    logic                    m_tlast;          // last

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    single_source_shortest_path dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    distance_board board = new();

    // idle chances in percent, changed per phase
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int live_items     = 0;   // items that the block does not simply drop
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // receiver: stalls at random, decided at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checking and watchdog, sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tlast);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus tasks, all entered just after a falling edge
    // ------------------------------------------------------------------------

    // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both lightly
    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
            default: begin send_gap_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic send_item(logic kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic [IN_W_W-1:0] w);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - 2 * NODE_W - IN_W_W){1'b0}}, w, b, a};
        do @(posedge aclk); while (!s_tready);
        // count everything the block does not merely drop
        if (kind == sssp_pkg::KIND_END ||
            (a != 0 && b != 0 && a <= board.live_nodes() && b <= board.live_nodes())) begin
            live_items++;
        end
        board.note_input(kind, a, b, w);
        @(negedge aclk);
    endtask

    task automatic send_edge(int a, int b, int w);
        send_item(sssp_pkg::KIND_EDGE, NODE_W'(a), NODE_W'(b), IN_W_W'(w));
    endtask

    task automatic send_end();
        send_item(sssp_pkg::KIND_END, NODE_W'($urandom), NODE_W'($urandom),
                  IN_W_W'($urandom));
    endtask

    // hold off the sender until every result is in and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_config(int count, int source);
        cfg_we    <= 1'b1;
        cfg_addr  <= sssp_pkg::REG_NODE_COUNT;
        cfg_wdata <= CFG_DW'(count);
        board.note_config(sssp_pkg::REG_NODE_COUNT, CFG_DW'(count));
        @(negedge aclk);
        cfg_addr  <= sssp_pkg::REG_SOURCE_NODE;
        cfg_wdata <= CFG_DW'(source);
        board.note_config(sssp_pkg::REG_SOURCE_NODE, CFG_DW'(source));
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // one random phase: a register setting and a few graphs
    task automatic random_phase(int mode);
        int pick, count, n, source, graphs, edges, a, b, w;
        pick = $urandom_range(99);
        if (pick < 8) begin
            count = MAX_NODES;
        end else if (pick < 12) begin
            count = $urandom_range(MAX_NODES + 1, 127);
        end else if (pick < 15) begin
            count = 0;
        end else if (pick < 18) begin
            count = 1;
        end else begin
            count = $urandom_range(2, 12);
        end
        n = (count > MAX_NODES) ? MAX_NODES : count;
        if ($urandom_range(99) < 85 && n > 0) begin
            source = $urandom_range(1, n);
        end else if ($urandom_range(1) == 0 || n >= 127) begin
            source = 0;
        end else begin
            source = $urandom_range(n + 1, 127);
        end

        drain();
        write_config(count, source);
        set_idling(mode);

        graphs = (n == MAX_NODES) ? 1 : $urandom_range(2, 4);
        repeat (graphs) begin
            edges = (n == MAX_NODES) ? $urandom_range(30, 60)
                                     : $urandom_range(0, 3 * ((n < 1) ? 1 : n));
            repeat (edges) begin
                if ($urandom_range(99) < 90 && n > 0) begin
                    a = $urandom_range(1, n);
                    b = $urandom_range(1, n);
                end else begin
                    // stray endpoints, node 0 or beyond the count
                    a = $urandom_range(0, 127);
                    b = $urandom_range(0, 127);
                end
                w = ($urandom_range(1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
                send_edge(a, b, w);
            end
            // now and then a graph is left open and runs on into the next phase
            if ($urandom_range(99) < 90) begin
                send_end();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        // default registers: 64 nodes from node 1, field extremes
        send_edge(1, 64, 65535);
        send_edge(64, 2, 0);
        send_edge(2, 2, 5);        // self loop
        send_edge(0, 3, 7);        // node 0 is dropped
        send_edge(3, 65, 1);       // beyond the node count
        send_edge(127, 127, 65535);
        send_edge(1, 3, 100);
        send_edge(3, 1, 50);       // smaller weight replaces
        send_edge(1, 3, 80);       // larger weight is kept out
        send_end();

        // count above the matrix size acts as full size, last node as source
        drain();
        write_config(127, 64);
        send_edge(64, 1, 1);
        send_edge(127, 64, 3);
        send_end();

        // zero nodes: nothing reported
        drain();
        write_config(0, 1);
        send_edge(1, 1, 1);
        send_end();

        // a single node reports nothing
        drain();
        write_config(1, 1);
        send_end();

        // bad sources still clear the matrix
        drain();
        write_config(5, 0);
        send_edge(1, 2, 3);
        send_end();
        drain();
        write_config(5, 6);
        send_end();

        // two nodes, widest weight, source at the top
        drain();
        write_config(2, 2);
        send_edge(1, 2, 65535);
        send_end();

        // random phases rotate through the idling mixes
        phase = 0;
        while (live_items < ITEM_TARGET) begin
            random_phase(phase);
            phase++;
        end

        // let the last results out, then watch for strays
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (TAIL_WAIT) @(negedge aclk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
